### src/ffca_pkg.sv
`timescale 1ns / 1ps

package ffca_pkg;

    localparam int CFG_W    = 9;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 9;
    localparam int START_W  = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXCEEDS   = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DIR_FULL  = 3'd4
    } t_status;

    typedef enum logic {
        MODE_CREATE = 1'b0,
        MODE_DELETE = 1'b1
    } t_mode;

    typedef struct packed {
        logic               mode;
        logic [KEY_W-1:0]   file_key;
        logic [COUNT_W-1:0] block_count;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] first_block;
        logic [COUNT_W-1:0] length;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_BSCAN,
        S_MARK,
        S_DIRWR,
        S_DSCAN,
        S_FREE,
        S_SHRD,
        S_SHWR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    bscan;
        logic    mark;
        logic    free;
        logic    dscan;
        logic    dir_wr;
        logic    sh_rd;
        logic    sh_wr;
        logic    cnt_dec;
        logic    resp;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_delete;
        logic exceeds;
        logic zero_cnt;
        logic dir_full;
        logic bfound;
        logic bmiss;
        logic mark_done;
        logic dfound;
        logic dmiss;
        logic sh_more;
        logic out_free;
    } t_sts;

endpackage

### src/ffca_ram.sv
`timescale 1ns / 1ps

module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ffca_ctrl.sv
`timescale 1ns / 1ps

module ffca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ffca_pkg::t_sts i_sts,
    output ffca_pkg::t_cmd o_cmd
);

    import ffca_pkg::*;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.is_delete) begin
                    n_state = S_DSCAN;
                end else if (i_sts.exceeds) begin
                    n_code  = ST_EXCEEDS;
                    n_state = S_RESP;
                end else if (i_sts.zero_cnt) begin
                    if (i_sts.dir_full) begin
                        n_code  = ST_DIR_FULL;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DIRWR;
                    end
                end else begin
                    n_state = S_BSCAN;
                end
            end
            S_BSCAN: begin
                if (i_sts.bfound) begin
                    if (i_sts.dir_full) begin
                        n_code  = ST_DIR_FULL;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_MARK;
                    end
                end else if (i_sts.bmiss) begin
                    n_code  = ST_NO_SPACE;
                    n_state = S_RESP;
                end
            end
            S_MARK: begin
                if (i_sts.mark_done) n_state = S_DIRWR;
            end
            S_DIRWR: begin
                n_code  = ST_OK;
                n_state = S_RESP;
            end
            S_DSCAN: begin
                if (i_sts.dfound) begin
                    n_state = S_FREE;
                end else if (i_sts.dmiss) begin
                    n_code  = ST_NOT_FOUND;
                    n_state = S_RESP;
                end
            end
            S_FREE: begin
                if (i_sts.mark_done) n_state = S_SHRD;
            end
            S_SHRD: begin
                if (i_sts.sh_more) begin
                    n_state = S_SHWR;
                end else begin
                    n_code  = ST_OK;
                    n_state = S_RESP;
                end
            end
            S_SHWR: begin
                n_state = S_SHRD;
            end
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: o_cmd.clr    = 1'b1;
            S_IDLE:  o_cmd.load   = i_in_valid;
            S_BSCAN: o_cmd.bscan  = 1'b1;
            S_MARK:  o_cmd.mark   = !i_sts.mark_done;
            S_DIRWR: o_cmd.dir_wr = 1'b1;
            S_DSCAN: o_cmd.dscan  = 1'b1;
            S_FREE:  o_cmd.free   = !i_sts.mark_done;
            S_SHRD: begin
                o_cmd.sh_rd   = i_sts.sh_more;
                o_cmd.cnt_dec = !i_sts.sh_more;
            end
            S_SHWR:  o_cmd.sh_wr  = 1'b1;
            S_RESP:  o_cmd.resp   = i_sts.out_free;
            default: o_cmd.resp   = 1'b0;
        endcase
    end

endmodule

### src/ffca_dp.sv
`timescale 1ns / 1ps

module ffca_dp #(
    parameter int MAX_BLOCKS  = 256,
    parameter int DIR_ENTRIES = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ffca_pkg::t_in_word                  i_in_word,
    input  logic                                i_cfg_we,
    input  logic [ffca_pkg::CFG_W-1:0]          i_cfg_data,
    input  ffca_pkg::t_cmd                      i_cmd,
    output ffca_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ffca_pkg::t_out_word                 o_out_word
);

    import ffca_pkg::*;

    localparam int BW   = $clog2(MAX_BLOCKS);
    localparam int BCW  = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = (BCW > COUNT_W) ? BCW : COUNT_W;
    localparam int DW   = $clog2(DIR_ENTRIES);
    localparam int DCW  = $clog2(DIR_ENTRIES + 1);
    localparam int DWID = KEY_W + BW + COUNT_W;

    logic [CFG_W-1:0]   r_total;
    logic               r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [BW-1:0]      r_start;
    logic [COUNT_W-1:0] r_len;
    logic [BCW-1:0]     r_clr_ptr;
    logic [BCW-1:0]     r_baddr;
    logic               r_bpend;
    logic [BW-1:0]      r_bidx;
    logic [CW-1:0]      r_run;
    logic               r_bfound;
    logic [CW-1:0]      r_mptr;
    logic [DCW-1:0]     r_cnt;
    logic [DCW-1:0]     r_daddr;
    logic               r_dpend;
    logic [DW-1:0]      r_didx;
    logic               r_dfound;
    logic [DW-1:0]      r_idx;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [CW-1:0]   total_sat, total_ext, run_n;
    logic            b_issue, d_issue, out_free, mark_done;
    logic            bram_we, bram_wdata, bram_rdata;
    logic [BW-1:0]   bram_waddr;
    logic            dram_we;
    logic [DW-1:0]   dram_raddr, dram_waddr, idx_next;
    logic [DWID-1:0] dram_wdata, dram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [BW-1:0]      rd_start;
    logic [COUNT_W-1:0] rd_len;

    assign total_ext = CW'(r_total);
    assign total_sat = (total_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : total_ext;
    assign run_n     = r_run + CW'(1);
    assign b_issue   = CW'(r_baddr) < total_sat;
    assign d_issue   = r_daddr < r_cnt;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign mark_done = r_mptr == CW'(r_len);
    assign idx_next  = r_idx + DW'(1);

    assign rd_key   = dram_rdata[DWID-1 -: KEY_W];
    assign rd_start = dram_rdata[COUNT_W +: BW];
    assign rd_len   = dram_rdata[COUNT_W-1:0];

    always_comb begin
        bram_we    = 1'b0;
        bram_wdata = 1'b0;
        bram_waddr = r_start + r_mptr[BW-1:0];
        if (i_cmd.clr) begin
            bram_we    = r_clr_ptr != BCW'(MAX_BLOCKS);
            bram_waddr = r_clr_ptr[BW-1:0];
        end else if (i_cmd.mark) begin
            bram_we    = 1'b1;
            bram_wdata = 1'b1;
        end else if (i_cmd.free) begin
            bram_we    = 1'b1;
        end
    end

    always_comb begin
        dram_raddr = i_cmd.sh_rd ? idx_next : r_daddr[DW-1:0];
        dram_we    = i_cmd.dir_wr || i_cmd.sh_wr;
        dram_waddr = i_cmd.sh_wr ? r_idx : r_cnt[DW-1:0];
        dram_wdata = i_cmd.sh_wr ? dram_rdata : {r_key, r_start, r_len};
    end

    ffca_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bram_we),
        .i_waddr (bram_waddr),
        .i_wdata (bram_wdata),
        .i_raddr (r_baddr[BW-1:0]),
        .o_rdata (bram_rdata)
    );

    ffca_ram #(.WIDTH(DWID), .DEPTH(DIR_ENTRIES)) u_dir (
        .i_clk   (i_clk),
        .i_we    (dram_we),
        .i_waddr (dram_waddr),
        .i_wdata (dram_wdata),
        .i_raddr (dram_raddr),
        .o_rdata (dram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= CFG_W'(256);
            r_clr_ptr   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_bpend     <= 1'b0;
            r_bfound    <= 1'b0;
            r_dpend     <= 1'b0;
            r_dfound    <= 1'b0;
        end else begin
            if (i_cfg_we) r_total <= i_cfg_data;
            if (i_cmd.clr && bram_we) r_clr_ptr <= r_clr_ptr + BCW'(1);

            if (i_cmd.load) begin
                r_mode   <= i_in_word.mode;
                r_key    <= i_in_word.file_key;
                r_len    <= i_in_word.block_count;
                r_start  <= '0;
                r_baddr  <= '0;
                r_bpend  <= 1'b0;
                r_run    <= '0;
                r_bfound <= 1'b0;
                r_mptr   <= '0;
                r_daddr  <= '0;
                r_dpend  <= 1'b0;
                r_dfound <= 1'b0;
            end

            if (i_cmd.bscan) begin
                r_baddr <= r_baddr + BCW'(b_issue);
                r_bpend <= b_issue;
                r_bidx  <= r_baddr[BW-1:0];
                if (r_bpend && !r_bfound) begin
                    if (bram_rdata) begin
                        r_run <= '0;
                    end else begin
                        r_run <= run_n;
                        if (run_n == CW'(r_len)) begin
                            r_bfound <= 1'b1;
                            r_start  <= BW'(CW'(r_bidx) + CW'(1) - CW'(r_len));
                        end
                    end
                end
            end

            if (i_cmd.mark || i_cmd.free) r_mptr <= r_mptr + CW'(1);

            if (i_cmd.dscan) begin
                r_daddr <= r_daddr + DCW'(d_issue);
                r_dpend <= d_issue;
                r_didx  <= r_daddr[DW-1:0];
                if (r_dpend && !r_dfound && rd_key == r_key) begin
                    r_dfound <= 1'b1;
                    r_idx    <= r_didx;
                    r_start  <= rd_start;
                    r_len    <= rd_len;
                end
            end

            if (i_cmd.sh_wr)   r_idx <= idx_next;
            if (i_cmd.dir_wr)  r_cnt <= r_cnt + DCW'(1);
            if (i_cmd.cnt_dec) r_cnt <= r_cnt - DCW'(1);

            if (i_cmd.resp) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_out_word.status <= i_cmd.code;
            if (i_cmd.code == ST_OK) begin
                r_out_word.first_block <= START_W'(r_start);
                r_out_word.length      <= r_len;
            end else begin
                r_out_word.first_block <= '0;
                r_out_word.length      <= '0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.clr_done  = r_clr_ptr == BCW'(MAX_BLOCKS);
        o_sts.is_delete = r_mode == MODE_DELETE;
        o_sts.exceeds   = CW'(r_len) > total_sat;
        o_sts.zero_cnt  = r_len == '0;
        o_sts.dir_full  = r_cnt >= DCW'(DIR_ENTRIES);
        o_sts.bfound    = r_bfound;
        o_sts.bmiss     = !r_bfound && !r_bpend && !b_issue;
        o_sts.mark_done = mark_done;
        o_sts.dfound    = r_dfound;
        o_sts.dmiss     = !r_dfound && !r_dpend && !d_issue;
        o_sts.sh_more   = (DCW'(r_idx) + DCW'(1)) < r_cnt;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DCW'(DIR_ENTRIES))
        else $error("directory count out of range");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bscan |-> !bram_we)
        else $error("bitmap written during scan");

    a_found_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dscan && r_dfound) |-> r_cnt != '0)
        else $error("match with empty directory");

    a_dir_wr_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dir_wr |-> r_cnt < DCW'(DIR_ENTRIES))
        else $error("append to full directory");

endmodule

### src/first_fit_contiguous_allocator.sv
`timescale 1ns / 1ps

// First-fit contiguous block allocator: a usage bitmap of MAX_BLOCKS blocks in one RAM
// and a directory of DIR_ENTRIES files in a second RAM. After reset the bitmap is
// cleared one block per cycle, so no word is taken until every block is clear; the
// total_blocks register may be written at any idle time. A create scans the bitmap one block
// per cycle, then marks count blocks one per cycle. A delete scans the directory one entry per
// cycle, frees the file's blocks one per cycle and moves each later entry down through a read
// state (S_SHRD) and a write state (S_SHWR). One request is in flight at a time; the next is
// taken while the previous result waits in the output register.
module first_fit_contiguous_allocator #(
    parameter int MAX_BLOCKS  = 256,
    parameter int DIR_ENTRIES = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ffca_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ffca_pkg::t_out_word        o_out_word,
    input  logic                       i_cfg_we,
    input  logic [ffca_pkg::CFG_W-1:0] i_cfg_data
);

    import ffca_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffca_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .DIR_ENTRIES (DIR_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

### verif/first_fit_contiguous_allocator_checker.sv
`timescale 1ns / 1ps

module first_fit_contiguous_allocator_checker #(
    parameter int MAX_BLOCKS  = 256,
    parameter int DIR_ENTRIES = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  ffca_pkg::t_in_word         i_in_word,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  ffca_pkg::t_out_word        i_out_word,
    input  logic                       i_cfg_we,
    input  logic [ffca_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_results_seen
);

    import ffca_pkg::*;

    logic [CFG_W-1:0]   total_reg;
    logic               block_map [MAX_BLOCKS];
    logic [KEY_W-1:0]   dir_key [DIR_ENTRIES];
    logic [START_W-1:0] dir_start [DIR_ENTRIES];
    logic [COUNT_W-1:0] dir_len [DIR_ENTRIES];
    int                 dir_used;
    t_out_word          expected_words[$];

    function automatic t_out_word alloc_result(t_in_word w);
        t_out_word r;
        int total, run, first, idx;
        bit hit;
        r = '0;
        r.status = ST_OK;
        hit = 0;
        first = 0;
        run = 0;
        idx = 0;
        if (w.mode == MODE_CREATE) begin
            total = (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : total_reg;
            if (w.block_count > total) begin
                r.status = ST_EXCEEDS;
                return r;
            end
            if (w.block_count == 0) begin
                hit = 1;
            end else begin
                for (int i = 0; i < total && !hit; i++) begin
                    if (block_map[i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == w.block_count) begin
                            first = i + 1 - w.block_count;
                            hit = 1;
                        end
                    end
                end
            end
            if (!hit) begin
                r.status = ST_NO_SPACE;
                return r;
            end
            if (dir_used >= DIR_ENTRIES) begin
                r.status = ST_DIR_FULL;
                return r;
            end
            for (int j = 0; j < w.block_count; j++) block_map[first + j] = 1'b1;
            dir_key[dir_used] = w.file_key;
            dir_start[dir_used] = START_W'(first);
            dir_len[dir_used] = w.block_count;
            dir_used++;
            r.first_block = START_W'(first);
            r.length = w.block_count;
        end else begin
            for (int i = 0; i < dir_used && !hit; i++) begin
                if (dir_key[i] == w.file_key) begin
                    idx = i;
                    hit = 1;
                end
            end
            if (!hit) begin
                r.status = ST_NOT_FOUND;
                return r;
            end
            r.first_block = dir_start[idx];
            r.length = dir_len[idx];
            for (int i = 0; i < dir_len[idx]; i++)
                if (dir_start[idx] + i < MAX_BLOCKS) block_map[dir_start[idx] + i] = 1'b0;
            for (int i = idx; i + 1 < dir_used; i++) begin
                dir_key[i] = dir_key[i + 1];
                dir_start[i] = dir_start[i + 1];
                dir_len[i] = dir_len[i + 1];
            end
            dir_used--;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            total_reg <= 9'd256;
            for (int i = 0; i < MAX_BLOCKS; i++) block_map[i] = 1'b0;
            dir_used = 0;
            expected_words.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_we) total_reg <= i_cfg_data;
            if (i_in_valid && !i_in_stall) expected_words.push_back(alloc_result(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected word %p", i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want.status !== i_out_word.status
                        || want.first_block !== i_out_word.first_block
                        || want.length !== i_out_word.length) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                want.status, want.first_block, want.length,
                                i_out_word.status, i_out_word.first_block,
                                i_out_word.length);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

### verif/first_fit_contiguous_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_contiguous_allocator_tb;
    import ffca_pkg::*;

    localparam int WATCHDOG = 200000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_word         in_word = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_word        out_word;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    int               fail_count, pending, results_seen;
    int               send_idle_pct = 0, recv_idle_pct = 0;
    int               quiet_cycles = 0;
    int               words_sent = 0;
    logic [KEY_W-1:0] live_keys[$];

    always #6 i_clk = ~i_clk;

    first_fit_contiguous_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    first_fit_contiguous_allocator_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_word      (in_word),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_word     (out_word),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(t_mode m, logic [KEY_W-1:0] k, logic [COUNT_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_valid <= 1'b1;
        in_word <= '{mode: m, file_key: k, block_count: n};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        in_valid <= 1'b0;
        words_sent++;
        if (m == MODE_CREATE) live_keys.push_back(k);
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_total(logic [CFG_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_word(int big_pct);
        logic [KEY_W-1:0] k;
        logic [COUNT_W-1:0] n;
        int r;
        r = $urandom_range(99);
        n = ($urandom_range(99) < big_pct) ? COUNT_W'($urandom_range(511))
                                           : COUNT_W'($urandom_range(12));
        if (r < 55) begin
            send_word(MODE_CREATE, ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom(), n);
        end else if (r < 90 && live_keys.size() > 0) begin
            r = $urandom_range(live_keys.size() - 1);
            k = live_keys[r];
            live_keys.delete(r);
            send_word(MODE_DELETE, k, COUNT_W'($urandom_range(511)));
        end else begin
            send_word(MODE_DELETE, $urandom(), n);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(MODE_CREATE, 32'h0, 9'd0);
        send_word(MODE_CREATE, 32'hFFFF_FFFF, 9'd256);
        send_word(MODE_CREATE, 32'h1, 9'd1);
        send_word(MODE_CREATE, 32'h2, 9'd511);
        send_word(MODE_DELETE, 32'h1234, 9'd0);
        send_word(MODE_DELETE, 32'hFFFF_FFFF, 9'h1FF);
        send_word(MODE_CREATE, 32'hA5A5_A5A5, 9'd100);
        send_word(MODE_CREATE, 32'h5A5A_5A5A, 9'd156);
        send_word(MODE_CREATE, 32'h3, 9'd1);
        send_word(MODE_DELETE, 32'hA5A5_A5A5, 9'd0);
        send_word(MODE_CREATE, 32'h4, 9'd101);
        send_word(MODE_CREATE, 32'h4, 9'd50);
        send_word(MODE_CREATE, 32'h4, 9'd50);
        send_word(MODE_DELETE, 32'h4, 9'd0);
        write_total(9'd0);
        send_word(MODE_CREATE, 32'h7, 9'd0);
        send_word(MODE_CREATE, 32'h8, 9'd1);
        write_total(9'd511);
        send_word(MODE_CREATE, 32'h9, 9'd50);
        write_total(9'd1);
        send_word(MODE_CREATE, 32'hA, 9'd1);
        send_word(MODE_DELETE, 32'h5A5A_5A5A, 9'd3);
        send_word(MODE_DELETE, 32'h0, 9'd0);
        write_total(9'd256);

        // fill the directory with zero-length files, then release them
        for (int i = 0; i < 130; i++) send_word(MODE_CREATE, 32'h100 + i, 9'd0);
        drain();
        for (int i = 0; i < 128; i++) send_word(MODE_DELETE, 32'h100 + i, 9'd0);
        drain();

        send_idle_pct = 29;
        recv_idle_pct = 45;
        for (int i = 0; i < 420; i++) random_word(8);
        write_total(9'd64);
        send_idle_pct = 45;
        recv_idle_pct = 29;
        for (int i = 0; i < 420; i++) random_word(8);
        write_total(9'd200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 250; i++) random_word(8);
        write_total(9'd256);
        for (int i = 0; i < 100; i++) random_word(40);

        drain();
        $display("Sent %0d words, %0d results checked: create/delete mix, totals 0 to 511,",
            words_sent, results_seen);
        $display("full directory, no-space and oversize cases, random stalls both sides.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
